>>> sv/gpi_pkg.sv
// Shared types, constants and kernel weights for the Gaussian pyramid block.
// Used by gpi_front, gpi_back and gaussian_pyramid_interp.
package gpi_pkg;

  localparam int MAX_DIM   = 256;
  localparam int IMG_AW    = 16;
  localparam int PYR_DEPTH = 21845;
  localparam int PYR_AW    = 15;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_BUILD = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  x_coord;
    logic [7:0]  y_coord;
    logic [3:0]  level;
    logic [31:0] pixel_value;
  } item_t;

  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
  } cfg_t;

  // 5-tap kernel in Q0.16
  function automatic logic [14:0] tap_weight(input logic [2:0] i);
    logic [14:0] w;
    case (i)
      3'd0, 3'd4: w = 15'd3277;
      3'd1, 3'd3: w = 15'd16384;
      3'd2:       w = 15'd26214;
      default:    w = 15'd0;
    endcase
    return w;
  endfunction

  function automatic logic [29:0] kernel_weight(input logic [2:0] i, input logic [2:0] j);
    return 30'(tap_weight(i)) * 30'(tap_weight(j));
  endfunction

  // Clamp a size register to 1..MAX_DIM
  function automatic logic [8:0] clamp_dim(input logic [8:0] v);
    logic [8:0] r;
    if (v == 9'd0) r = 9'd1;
    else if (v > 9'(MAX_DIM)) r = 9'(MAX_DIM);
    else r = v;
    return r;
  endfunction

endpackage

>>> sv/gpi_front.sv
// Input side: takes stream requests, drops unused codes, queues the rest.
// Depends on gpi_pkg.
module gpi_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [55:0]        s_tdata,
  output logic               q_valid,
  output gpi_pkg::item_t     q_item,
  input  logic               q_pop
);

  gpi_pkg::item_t         fifo [gpi_pkg::Q_DEPTH];
  logic [gpi_pkg::Q_AW-1:0] head;
  logic [gpi_pkg::Q_AW-1:0] tail;
  logic [gpi_pkg::Q_AW:0]   count;
  gpi_pkg::item_t         in_item;
  logic                   push;
  logic                   pop;

  // Unpack the request, lowest field first
  assign in_item.mode        = s_tdata[1:0];
  assign in_item.x_coord     = s_tdata[9:2];
  assign in_item.y_coord     = s_tdata[17:10];
  assign in_item.level       = s_tdata[21:18];
  assign in_item.pixel_value = s_tdata[53:22];

  assign s_tready = (count != (gpi_pkg::Q_AW+1)'(gpi_pkg::Q_DEPTH));
  assign push     = s_tvalid && s_tready && (in_item.mode != gpi_pkg::MODE_NONE);
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = fifo[head];

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[tail] <= in_item;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= tail + 1'b1;
      if (pop) head <= head + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> sv/gpi_back.sv
// Execution engine: image and pyramid memories, build sequencer, query unit.
// Depends on gpi_pkg.
module gpi_back (
  input  logic           clk,
  input  logic           rst,
  input  gpi_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  gpi_pkg::item_t q_item,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [31:0]    m_tdata,
  output logic           m_tuser
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_QSET  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_BWR   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [31:0] img_mem [2**gpi_pkg::IMG_AW];
  logic [31:0] pyr_mem [gpi_pkg::PYR_DEPTH];

  logic [2:0]  state;
  logic [8:0]  w_eff, h_eff;

  // pyramid shape
  logic [3:0]  level_count;
  logic [2:0]  base_lg;

  // build walk
  logic [3:0]  lvl_k;
  logic [2:0]  lgs;
  logic [6:0]  px, py;
  logic [14:0] wp, src_off, lvl_start;
  logic        is_build;

  // query setup
  logic [7:0]  qin_x, qin_y;
  logic [3:0]  qin_lvl;
  logic        q_zero;
  logic [3:0]  q_l;
  logic [2:0]  q_lg;
  logic [7:0]  qx0, qx1, qy0, qy1;
  logic [8:0]  qfx, qfy, qside;
  logic [14:0] q_off;

  // taps and datapath
  logic [2:0]  tap_i, tap_j;
  logic [63:0] acc;
  logic        acc_clr;
  logic [31:0] res;
  logic        v1, ok1, sel1, v2;
  logic [29:0] w1;
  logic [31:0] rd_img, rd_pyr;
  logic [63:0] prod2;

  // issue signals
  logic                      is_ok, is_img, is_last;
  logic [29:0]               is_w;
  logic [gpi_pkg::IMG_AW-1:0] img_ra;
  logic [gpi_pkg::PYR_AW-1:0] pyr_ra;
  logic signed [9:0]         sx, sy;
  logic [8:0]                src_side;
  logic [7:0]                qxs, qys;
  logic [8:0]                wx, wy;

  // setup helpers
  logic [8:0]  maxd;
  logic [3:0]  lc_calc;
  logic [3:0]  l_calc;
  logic [2:0]  lg_calc;
  logic [8:0]  side_calc, l_pow;
  logic [7:0]  x0_c, y0_c, x1_c, y1_c;
  logic [8:0]  fx_c, fy_c;
  logic [16:0] off_sum;
  logic [5:0]  sh;
  logic [63:0] rounded;
  logic [31:0] mdata;
  logic [61:0] mul;
  logic [6:0]  smax;
  logic        img_we;
  logic        out_load;

  assign w_eff = gpi_pkg::clamp_dim(cfg.width);
  assign h_eff = gpi_pkg::clamp_dim(cfg.height);
  assign maxd  = (h_eff > w_eff) ? h_eff : w_eff;

  // Level count is the number of powers of two below the larger side
  always_comb begin
    lc_calc = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if ((9'd1 << i) < maxd) lc_calc = 4'(i + 1);
    end
  end

  assign q_pop  = (state == ST_IDLE) && q_valid;
  assign img_we = q_pop && (q_item.mode == gpi_pkg::MODE_LOAD);

  // Query geometry from the latched request
  always_comb begin
    l_calc    = (qin_lvl > level_count) ? level_count : qin_lvl;
    lg_calc   = 3'(4'(base_lg) + 4'd1 - l_calc);
    side_calc = 9'd1 << lg_calc;
    l_pow     = 9'd1 << l_calc;
    x0_c      = qin_x >> l_calc;
    y0_c      = qin_y >> l_calc;
    fx_c      = {1'b0, qin_x} & (l_pow - 9'd1);
    fy_c      = {1'b0, qin_y} & (l_pow - 9'd1);
    x1_c      = x0_c + 8'd1;
    y1_c      = y0_c + 8'd1;
    if ({1'b0, x0_c} + 9'd1 >= side_calc) begin
      x0_c = 8'(side_calc - 9'd1);
      x1_c = x0_c;
      fx_c = 9'd0;
    end
    if ({1'b0, y0_c} + 9'd1 >= side_calc) begin
      y0_c = 8'(side_calc - 9'd1);
      y1_c = y0_c;
      fy_c = 9'd0;
    end
    off_sum = 17'd0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) + 4'd1 < l_calc) off_sum = off_sum + (17'd1 << (2 * (base_lg - 3'(i))));
    end
  end

  // Read address and weight for the current tap
  always_comb begin
    src_side = 9'd1 << (lgs + 3'd1);
    sx       = $signed({2'b00, px, 1'b0}) + $signed({7'b0, tap_i}) - 10'sd2;
    sy       = $signed({2'b00, py, 1'b0}) + $signed({7'b0, tap_j}) - 10'sd2;
    qxs      = tap_i[0] ? qx1 : qx0;
    qys      = tap_i[1] ? qy1 : qy0;
    wx       = tap_i[0] ? qfx : (qside - qfx);
    wy       = tap_i[1] ? qfy : (qside - qfy);
    img_ra   = {qin_y, qin_x};
    pyr_ra   = q_off + 15'({7'b0, qys} << q_lg) + 15'(qxs);
    is_ok    = 1'b1;
    is_img   = 1'b0;
    is_w     = 30'(wx * wy);
    is_last  = (tap_i == 3'd3);
    if (is_build) begin
      is_w    = gpi_pkg::kernel_weight(tap_i, tap_j);
      is_last = (tap_i == 3'd4) && (tap_j == 3'd4);
      img_ra  = {sy[7:0], sx[7:0]};
      pyr_ra  = src_off + 15'({8'b0, sy[7:0]} << (lgs + 3'd1)) + 15'(sx[7:0]);
      if (lvl_k == 4'd0) begin
        is_img = 1'b1;
        is_ok  = (sx >= 0) && (sy >= 0) && (sx < $signed({1'b0, w_eff}))
                 && (sy < $signed({1'b0, h_eff}));
      end else begin
        is_ok  = (sx >= 0) && (sy >= 0) && (sx < $signed({1'b0, src_side}))
                 && (sy < $signed({1'b0, src_side}));
      end
    end else if (q_zero) begin
      is_img  = 1'b1;
      is_w    = 30'd1;
      is_last = 1'b1;
      is_ok   = ({1'b0, qin_x} < w_eff) && ({1'b0, qin_y} < h_eff);
    end
  end

  // Round half up by twice the level for a query, by 32 bits for a build
  always_comb begin
    if (is_build) sh = 6'd32;
    else sh = {1'b0, q_l, 1'b0};
    if (sh == 6'd0) rounded = acc;
    else rounded = (acc + (64'd1 << (sh - 6'd1))) >> sh;
  end

  assign mdata = ok1 ? (sel1 ? rd_img : rd_pyr) : 32'd0;
  assign mul   = 62'(mdata) * 62'(w1);
  assign smax  = 7'((8'd1 << lgs) - 8'd1);

  // Memories
  always_ff @(posedge clk) begin
    if (img_we) img_mem[{q_item.y_coord, q_item.x_coord}] <= q_item.pixel_value;
    rd_img <= img_mem[img_ra];
  end

  always_ff @(posedge clk) begin
    if (state == ST_BWR) pyr_mem[wp] <= res;
    rd_pyr <= pyr_mem[pyr_ra];
  end

  // Read, multiply, accumulate pipeline
  always_ff @(posedge clk) begin
    ok1   <= is_ok;
    sel1  <= is_img;
    w1    <= is_w;
    prod2 <= 64'(mul);
    if (acc_clr) acc <= 64'd0;
    else if (v2) acc <= acc + prod2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == ST_RUN);
      v2 <= v1;
    end
  end

  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  // Sequencer
  always_ff @(posedge clk) begin
    acc_clr <= 1'b0;
    if (rst) begin
      state       <= ST_IDLE;
      level_count <= 4'd0;
      base_lg     <= 3'd0;
      is_build    <= 1'b0;
      tap_i       <= 3'd0;
      tap_j       <= 3'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            qin_x   <= q_item.x_coord;
            qin_y   <= q_item.y_coord;
            qin_lvl <= q_item.level;
            tap_i   <= 3'd0;
            tap_j   <= 3'd0;
            acc_clr <= 1'b1;
            if (q_item.mode == gpi_pkg::MODE_BUILD) begin
              is_build    <= 1'b1;
              level_count <= lc_calc;
              base_lg     <= 3'(lc_calc - 4'd1);
              lgs         <= 3'(lc_calc - 4'd1);
              lvl_k       <= 4'd0;
              px          <= 7'd0;
              py          <= 7'd0;
              wp          <= 15'd0;
              src_off     <= 15'd0;
              lvl_start   <= 15'd0;
              res         <= 32'd0;
              state       <= (lc_calc == 4'd0) ? ST_OUT : ST_RUN;
            end else if (q_item.mode == gpi_pkg::MODE_QUERY) begin
              is_build <= 1'b0;
              state    <= ST_QSET;
            end
          end
        end
        ST_QSET: begin
          q_l    <= l_calc;
          q_zero <= (l_calc == 4'd0);
          q_lg   <= lg_calc;
          qx0    <= x0_c;
          qx1    <= x1_c;
          qy0    <= y0_c;
          qy1    <= y1_c;
          qfx    <= fx_c;
          qfy    <= fy_c;
          qside  <= l_pow;
          q_off  <= 15'(off_sum);
          state  <= ST_RUN;
        end
        ST_RUN: begin
          if (is_last) begin
            state <= ST_DRAIN;
          end else if (is_build && tap_i == 3'd4) begin
            tap_i <= 3'd0;
            tap_j <= tap_j + 3'd1;
          end else begin
            tap_i <= tap_i + 3'd1;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2) begin
            res   <= rounded[31:0];
            state <= is_build ? ST_BWR : ST_OUT;
          end
        end
        ST_BWR: begin
          wp      <= wp + 15'd1;
          tap_i   <= 3'd0;
          tap_j   <= 3'd0;
          acc_clr <= 1'b1;
          state   <= ST_RUN;
          if (px != smax) begin
            px <= px + 7'd1;
          end else begin
            px <= 7'd0;
            if (py != smax) begin
              py <= py + 7'd1;
            end else begin
              py <= 7'd0;
              if (lvl_k + 4'd1 == level_count) begin
                res   <= 32'd0;
                state <= ST_OUT;
              end else begin
                lvl_k     <= lvl_k + 4'd1;
                lgs       <= lgs - 3'd1;
                src_off   <= lvl_start;
                lvl_start <= wp + 15'd1;
              end
            end
          end
        end
        ST_OUT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res;
      m_tuser <= is_build ? gpi_pkg::KIND_BUILD : gpi_pkg::KIND_QUERY;
    end
  end

endmodule

>>> sv/gaussian_pyramid_interp.sv
// Top level: size registers on the APB port, input queue and execution engine.
// Depends on gpi_pkg, gpi_front and gpi_back.
//
//  channel  | direction | payload
//  s_*      | in        | tdata: mode, x_coord, y_coord, level, pixel_value
//  m_*      | out       | tdata: result_value; tuser: result_kind
//  APB      | in/out    | width register at 0x0, height register at 0x4
//
// A load writes the image memory as it leaves the queue; a level-0 query reads
// one image pixel; a higher query does one pyramid read per neighbor through a
// single multiplier. A build reduces each pyramid pixel from 25 kernel reads
// through one memory port, then round and write back. No clearing pass after reset.
// Synchronous reset clears control and shape; memories keep content.
// The input queue holds four requests while the engine or output stalls.
module gaussian_pyramid_interp (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // mode[1:0] x_coord[9:2] y_coord[17:10] level[21:18] pixel[53:22]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value[31:0]
  output logic        m_tuser,   // result_kind[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gpi_pkg::cfg_t  cfg;
  logic           q_valid;
  gpi_pkg::item_t q_item;
  logic           q_pop;
  logic           cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == gpi_pkg::REG_HEIGHT) ? {23'b0, cfg.height} : {23'b0, cfg.width};

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= 9'(gpi_pkg::MAX_DIM);
      cfg.height <= 9'(gpi_pkg::MAX_DIM);
    end else if (cfg_we) begin
      if (paddr[2] == gpi_pkg::REG_WIDTH) cfg.width <= pwdata[8:0];
      else cfg.height <= pwdata[8:0];
    end
  end

  gpi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  gpi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A build completion carries a zero value
  a_build_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == gpi_pkg::KIND_BUILD) |-> m_tdata == 32'd0)
    else $error("build result carries nonzero value");

  // Width write lands in the register
  a_width_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (paddr[2] == gpi_pkg::REG_WIDTH) |=> cfg.width == $past(pwdata[8:0]))
    else $error("width register not updated");

  // Reset leaves no result pending
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

>>> sim/gaussian_pyramid_interp_tb.sv
// Self-checking testbench for gaussian_pyramid_interp: loads images, builds
// pyramids and queries them under random stalls, against an in-bench predictor.
// Depends on gpi_pkg and the gaussian_pyramid_interp RTL.
`timescale 1ns / 1ps

module gaussian_pyramid_interp_tb;

  localparam int SIDE_MAX   = 256;
  localparam int STALL_MAX  = 200000;
  localparam int SETTLE_CYC = 40;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [3:0]  lvl;
    logic [31:0] pix;
    bit          typed;
    logic [31:0] val;
    logic        kind;
  } row_t;

  typedef struct {
    logic [31:0] val;
    logic        kind;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // mode, x_coord, y_coord, level, pixel_value, zero fill
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // result_value
  logic        m_tuser;   // result_kind
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gaussian_pyramid_interp dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state
  logic [31:0] img_mem [SIDE_MAX*SIDE_MAX];
  bit          img_loaded [SIDE_MAX*SIDE_MAX];
  logic [31:0] pyr_mem [gpi_pkg::PYR_DEPTH+4];
  int          lvl_count;
  int          base_len;
  int          cfg_w;
  int          cfg_h;
  int unsigned taps [5] = '{3277, 16384, 26214, 16384, 3277};

  answer_t pending_results [$];
  int      errors;
  int      n_sent;
  int      n_queries;
  int      n_builds;
  int      n_got;
  int      idle_cycles;
  bit      calm;

  function automatic int eff_dim(input int v);
    if (v < 1) return 1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return v;
  endfunction

  function automatic logic [31:0] image_pixel(input int x, input int y);
    if (x < 0 || y < 0 || x >= eff_dim(cfg_w) || y >= eff_dim(cfg_h)) return 32'd0;
    return img_mem[y*SIDE_MAX + x];
  endfunction

  function automatic int level_base(input int k);
    int off;
    off = 0;
    for (int i = 0; i < k; i++) off += (base_len >> i) * (base_len >> i);
    return off;
  endfunction

  function automatic logic [31:0] pyr_pixel(input int k, input int x, input int y);
    int side;
    side = base_len >> k;
    if (x < 0 || y < 0 || x >= side || y >= side) return 32'd0;
    return pyr_mem[level_base(k) + y*side + x];
  endfunction

  // Reduce the image into all pyramid levels, round half up
  function automatic void pyr_build();
    int maxd, p, side, off, sx, sy;
    logic [63:0] sum, v;
    maxd = eff_dim(cfg_w) > eff_dim(cfg_h) ? eff_dim(cfg_w) : eff_dim(cfg_h);
    base_len = 0;
    lvl_count = 0;
    p = 1;
    while (p < maxd) begin
      base_len = p;
      lvl_count++;
      p <<= 1;
    end
    for (int k = 0; k < lvl_count; k++) begin
      side = base_len >> k;
      off = level_base(k);
      for (int y = 0; y < side; y++) begin
        for (int x = 0; x < side; x++) begin
          sum = 64'd0;
          for (int j = 0; j < 5; j++) begin
            for (int i = 0; i < 5; i++) begin
              sx = 2*x + i - 2;
              sy = 2*y + j - 2;
              v = (k == 0) ? 64'(image_pixel(sx, sy)) : 64'(pyr_pixel(k-1, sx, sy));
              sum += 64'(taps[i] * taps[j]) * v;
            end
          end
          pyr_mem[off + y*side + x] = 32'((sum + 64'h8000_0000) >> 32);
        end
      end
    end
  endfunction

  // Bilinear lookup with edge clamp
  function automatic logic [31:0] interp_lookup(input int x, input int y, input int lvl);
    int l, size, x0, y0, x1, y1, fx, fy;
    logic [63:0] acc;
    if (lvl > lvl_count) lvl = lvl_count;
    if (lvl == 0) return image_pixel(x, y);
    l = 1 << lvl;
    size = base_len >> (lvl - 1);
    x0 = x >> lvl;
    y0 = y >> lvl;
    fx = x & (l - 1);
    fy = y & (l - 1);
    if (x0 + 1 >= size) begin
      x0 = size - 1; x1 = x0; fx = 0;
    end else x1 = x0 + 1;
    if (y0 + 1 >= size) begin
      y0 = size - 1; y1 = y0; fy = 0;
    end else y1 = y0 + 1;
    acc = 64'(pyr_pixel(lvl-1, x0, y0)) * 64'((l - fx) * (l - fy))
        + 64'(pyr_pixel(lvl-1, x1, y0)) * 64'(fx * (l - fy))
        + 64'(pyr_pixel(lvl-1, x0, y1)) * 64'((l - fx) * fy)
        + 64'(pyr_pixel(lvl-1, x1, y1)) * 64'(fx * fy);
    acc += 64'd1 << (2*lvl - 1);
    return 32'(acc >> (2*lvl));
  endfunction

  function automatic logic [31:0] rand_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'd0;
    if (r < 16) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hand one request to the block and record what it should answer
  task automatic issue(input row_t r);
    int g, gap;
    answer_t a;
    g = $urandom_range(0, 99);
    gap = calm ? 0 : (g < 60 ? 0 : (g < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, r.pix, r.lvl, r.y, r.x, r.mode};
    do @(posedge clk); while (!s_tready);
    n_sent++;
    case (r.mode)
      gpi_pkg::MODE_LOAD: begin
        img_mem[{r.y, r.x}] = r.pix;
        img_loaded[{r.y, r.x}] = 1'b1;
      end
      gpi_pkg::MODE_BUILD: begin
        pyr_build();
        n_builds++;
        a.val = 32'd0;
        a.kind = gpi_pkg::KIND_BUILD;
        pending_results.push_back(a);
      end
      gpi_pkg::MODE_QUERY: begin
        a.val = interp_lookup(r.x, r.y, r.lvl);
        a.kind = gpi_pkg::KIND_QUERY;
        if (r.typed) a.val = r.val;
        n_queries++;
        pending_results.push_back(a);
      end
      default: ;
    endcase
  endtask

  // Wait for all answers, then let trailing loads settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == gpi_pkg::REG_WIDTH) cfg_w = val[8:0];
    else cfg_h = val[8:0];
  endtask

  task automatic set_size(input int w, input int h);
    drain();
    reg_write(3'(4 * gpi_pkg::REG_WIDTH), 32'(w));
    reg_write(3'(4 * gpi_pkg::REG_HEIGHT), 32'(h));
  endtask

  // Load every in-image pixel that was never written
  task automatic fill_image();
    row_t r;
    r = '{default: '0};
    r.mode = gpi_pkg::MODE_LOAD;
    for (int y = 0; y < eff_dim(cfg_h); y++) begin
      for (int x = 0; x < eff_dim(cfg_w); x++) begin
        if (!img_loaded[y*SIDE_MAX + x]) begin
          r.x = 8'(x);
          r.y = 8'(y);
          r.pix = rand_pixel();
          r.lvl = 4'($urandom);
          issue(r);
        end
      end
    end
  endtask

  // Mostly queries, with stray loads, rebuilds and unused-mode noise
  task automatic random_mix(input int count, input bit may_build);
    row_t r;
    int c;
    for (int n = 0; n < count; n++) begin
      r = '{default: '0};
      c = $urandom_range(0, 99);
      r.x = 8'($urandom);
      r.y = 8'($urandom);
      r.lvl = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
      r.pix = rand_pixel();
      if (c < 12) r.mode = gpi_pkg::MODE_LOAD;
      else if (c < 17) r.mode = gpi_pkg::MODE_NONE;
      else if (c < 21 && may_build) r.mode = gpi_pkg::MODE_BUILD;
      else r.mode = gpi_pkg::MODE_QUERY;
      issue(r);
      if (n % 25 == 0) calm = ($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic phase(input int w, input int h, input bit may_build, input int count);
    row_t r;
    set_size(w, h);
    fill_image();
    if (may_build) begin
      r = '{default: '0};
      r.mode = gpi_pkg::MODE_BUILD;
      issue(r);
    end
    random_mix(count, may_build);
  endtask

  // Receiver stall pattern
  initial begin
    int g;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      g = $urandom_range(0, 99);
      if (g < 70) begin
        m_tready <= 1'b0;
        repeat (g < 55 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  // Compare each answer with the oldest expectation
  always @(posedge clk) begin
    answer_t a;
    if (!rst && m_tvalid && m_tready) begin
      n_got++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %h kind %0d", m_tdata, m_tuser);
        errors++;
      end else begin
        a = pending_results.pop_front();
        if (m_tdata !== a.val) begin
          $error("result_value mismatch: expected %h actual %h", a.val, m_tdata);
          errors++;
        end
        if (m_tuser !== a.kind) begin
          $error("result_kind mismatch: expected %0d actual %0d", a.kind, m_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request, result or register access
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus
  initial begin
    row_t dir_rows [$];
    errors = 0; n_sent = 0; n_queries = 0; n_builds = 0; n_got = 0;
    calm = 1'b0;
    lvl_count = 0; base_len = 0; cfg_w = SIDE_MAX; cfg_h = SIDE_MAX;
    foreach (img_loaded[i]) img_loaded[i] = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 3x2 image, extremes of pixels, all modes, clamps and edges
    set_size(3, 2);
    dir_rows = '{
      '{gpi_pkg::MODE_LOAD,  8'd0,   8'd0,   4'd0,  32'hFFFF_FFFF, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_LOAD,  8'd1,   8'd0,   4'd15, 32'h0000_0000, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_LOAD,  8'd2,   8'd0,   4'd0,  32'h1234_5678, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_LOAD,  8'd0,   8'd1,   4'd0,  32'h8000_0000, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_LOAD,  8'd1,   8'd1,   4'd0,  32'hFFFF_FFFF, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_LOAD,  8'd2,   8'd1,   4'd0,  32'h0000_0001, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_LOAD,  8'd255, 8'd255, 4'd0,  32'hA5A5_A5A5, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_QUERY, 8'd0,   8'd0,   4'd0,  32'd0, 1, 32'hFFFF_FFFF, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_QUERY, 8'd2,   8'd1,   4'd15, 32'd0, 1, 32'h0000_0001, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_QUERY, 8'd255, 8'd255, 4'd0,  32'd0, 1, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_QUERY, 8'd3,   8'd0,   4'd0,  32'd0, 1, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_NONE,  8'd255, 8'd255, 4'd15, 32'hFFFF_FFFF, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_BUILD, 8'd0,   8'd0,   4'd0,  32'd0, 1, 32'd0, gpi_pkg::KIND_BUILD},
      '{gpi_pkg::MODE_QUERY, 8'd0,   8'd0,   4'd1,  32'd0, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_QUERY, 8'd1,   8'd1,   4'd1,  32'd0, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_QUERY, 8'd3,   8'd2,   4'd2,  32'd0, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_QUERY, 8'd255, 8'd255, 4'd15, 32'd0, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_QUERY, 8'd1,   8'd0,   4'd8,  32'd0, 0, 32'd0, gpi_pkg::KIND_QUERY},
      '{gpi_pkg::MODE_QUERY, 8'd2,   8'd1,   4'd0,  32'd0, 1, 32'h0000_0001, gpi_pkg::KIND_QUERY}
    };
    foreach (dir_rows[i]) issue(dir_rows[i]);
    random_mix(60, 1'b1);

    // Random phases over several sizes, clamped register values among them
    phase(1, 1, 1'b1, 80);
    phase(0, 7, 1'b1, 80);
    phase(16, 16, 1'b1, 120);
    phase(33, 3, 1'b1, 90);
    phase(256, 1, 1'b0, 80);
    phase(511, 0, 1'b0, 60);
    phase(5, 9, 1'b1, 100);

    drain();
    $display("sent %0d requests: %0d queries, %0d builds; %0d results checked",
             n_sent, n_queries, n_builds, n_got);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
